// ===== src/idq_pkg.sv =====
`default_nettype none

package idq_pkg;

    // Fixed field widths of the item ports
    localparam int CMD_W       = 3;
    localparam int IDX_W       = 4;
    localparam int DATA_IN_W   = 32;
    localparam int DATA_OUT_W  = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_GET        = 3'd4,
        CMD_SET        = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RDATA,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== src/indexed_double_ended_queue_top.sv =====
`default_nettype none

// Indexed double-ended queue: an ordered list of up to CAPACITY words kept in
// a ring store addressed by a front pointer and an entry count. Each input item
// is one command (push front, push back, remove at index, pop back, get at
// index, set at index) and yields exactly one result item with the word removed
// or read (zero unless the status is ok), a status (ok, index out of range or
// list empty, list full) and the entry count after the command. The block works
// on one item at a time: o_in_ready is high only while the sequencer is idle.
// Push, set and any refused command go from the decode state straight to the
// finish state; get and pop back also pass a read-data state; remove at index
// i also passes it and then moves each later entry down by one read and one
// write through the single port of the ring store, all slot addresses coming
// from one shared modulo adder. A finished result sits in an output register,
// so the block takes the next item while it waits for i_out_ready. The store
// has no reset; its entries are read only after they were written. Data words
// are kept to DATA_WIDTH bits and shown zero-extended on the 32-bit data port.
module indexed_double_ended_queue_top #(
    parameter int CAPACITY   = idq_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = idq_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [idq_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [idq_pkg::IDX_W-1:0]          i_index,
    input  wire logic [idq_pkg::DATA_IN_W-1:0]      i_data_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [idq_pkg::DATA_OUT_W-1:0]     o_data_out,
    output logic      [idq_pkg::STATUS_W-1:0]       o_status,
    output logic      [idq_pkg::COUNT_OUT_W-1:0]    o_count_out
);
    import idq_pkg::*;

    // Ring slot address width
    localparam int ADDR_W = $clog2(CAPACITY);

    t_mem_ctl              w_mem_ctl;
    logic [ADDR_W-1:0]     w_mem_addr;
    logic [DATA_WIDTH-1:0] w_mem_wdata;
    logic [DATA_WIDTH-1:0] w_mem_rdata;

    // Sequencer: decode, range checks, ring address unit, shift loop, result
    idq_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_index     (i_index),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count_out (o_count_out),
        .o_mem_ctl   (w_mem_ctl),
        .o_mem_addr  (w_mem_addr),
        .o_mem_wdata (w_mem_wdata),
        .i_mem_rdata (w_mem_rdata)
    );

    // Ring store: one address a cycle, registered read data
    idq_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

endmodule

`default_nettype wire

// ===== src/idq_store.sv =====
`default_nettype none

module idq_store #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 4
) (
    input  wire logic                  i_clk,
    input  wire idq_pkg::t_mem_ctl     i_ctl,
    input  wire logic [ADDR_W-1:0]     i_addr,
    input  wire logic [DATA_WIDTH-1:0] i_wdata,
    output logic      [DATA_WIDTH-1:0] o_rdata
);
    import idq_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/idq_seq.sv =====
`default_nettype none

module idq_seq #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int ADDR_W     = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [idq_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic [idq_pkg::IDX_W-1:0]          i_index,
    input  wire logic [idq_pkg::DATA_IN_W-1:0]      i_data_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [idq_pkg::DATA_OUT_W-1:0]     o_data_out,
    output logic      [idq_pkg::STATUS_W-1:0]       o_status,
    output logic      [idq_pkg::COUNT_OUT_W-1:0]    o_count_out,
    output idq_pkg::t_mem_ctl                       o_mem_ctl,
    output logic      [ADDR_W-1:0]                  o_mem_addr,
    output logic      [DATA_WIDTH-1:0]              o_mem_wdata,
    input  wire logic [DATA_WIDTH-1:0]              i_mem_rdata
);
    import idq_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > IDX_W) ? CW : IDX_W) + 1;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [DATA_WIDTH-1:0] r_word, n_word;
    logic [ADDR_W-1:0]     r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic [ADDR_W-1:0]     r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_dout, n_dout;
    t_status               r_res_status, n_res_status;
    logic                  r_out_valid, n_out_valid;
    logic [DATA_OUT_W-1:0] r_out_data, n_out_data;
    t_status               r_out_status, n_out_status;
    logic [COUNT_OUT_W-1:0] r_out_count, n_out_count;

    logic [ADDR_W-1:0] w_pos;
    logic [ADDR_W:0]   w_sum;
    logic [ADDR_W-1:0] w_slot;
    logic              w_full;
    logic              w_empty;
    logic              w_idx_bad;
    logic              w_idx_more;
    logic              w_shift_more;

    // Shared ring address unit: slot = (front + pos) mod CAPACITY
    always_comb begin
        unique case (r_state)
            S_DECODE: begin
                unique case (r_cmd) inside
                    CMD_PUSH_FRONT: w_pos = ADDR_W'(CAPACITY - 1);
                    CMD_PUSH_BACK:  w_pos = ADDR_W'(r_count);
                    CMD_POP_BACK:   w_pos = ADDR_W'(r_count - CW'(1));
                    default:        w_pos = ADDR_W'(r_idx);
                endcase
            end
            S_SHIFT_RD: w_pos = r_pos + ADDR_W'(1);
            default:    w_pos = r_pos;
        endcase
    end

    assign w_sum  = {1'b0, r_front} + {1'b0, w_pos};
    assign w_slot = (w_sum >= (ADDR_W + 1)'(CAPACITY)) ?
                    ADDR_W'(w_sum - (ADDR_W + 1)'(CAPACITY)) : ADDR_W'(w_sum);

    assign w_full       = (r_count == CW'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_idx_bad    = (CMPW'(r_idx) >= CMPW'(r_count));
    assign w_idx_more   = ((CMPW'(r_idx) + CMPW'(1)) < CMPW'(r_count));
    assign w_shift_more = ((CMPW'(r_pos) + CMPW'(2)) < CMPW'(r_count));

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_word       = r_word;
        n_front      = r_front;
        n_count      = r_count;
        n_pos        = r_pos;
        n_dout       = r_dout;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        o_mem_ctl    = '0;
        o_mem_addr   = w_slot;
        o_mem_wdata  = r_word;
        o_in_ready   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = t_cmd'(i_cmd);
                    n_idx   = i_index;
                    n_word  = DATA_WIDTH'(i_data_in);
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_dout       = '0;
                n_res_status = ST_OK;
                n_state      = S_DONE;
                unique case (r_cmd) inside
                    CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                        if (w_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            o_mem_ctl.wr_en = 1'b1;
                            n_count         = r_count + CW'(1);
                            if (r_cmd == CMD_PUSH_FRONT) begin
                                n_front = w_slot;
                            end
                        end
                    end
                    CMD_REMOVE, CMD_GET: begin
                        if (w_idx_bad) begin
                            n_res_status = ST_RANGE;
                        end else begin
                            o_mem_ctl.rd_en = 1'b1;
                            n_state         = S_RDATA;
                        end
                    end
                    CMD_POP_BACK: begin
                        if (w_empty) begin
                            n_res_status = ST_RANGE;
                        end else begin
                            o_mem_ctl.rd_en = 1'b1;
                            n_state         = S_RDATA;
                        end
                    end
                    CMD_SET: begin
                        if (w_idx_bad) begin
                            n_res_status = ST_RANGE;
                        end else begin
                            o_mem_ctl.wr_en = 1'b1;
                        end
                    end
                    default: begin
                        n_res_status = ST_RANGE;
                    end
                endcase
            end
            S_RDATA: begin
                n_dout  = i_mem_rdata;
                n_state = S_DONE;
                if (r_cmd == CMD_POP_BACK) begin
                    n_count = r_count - CW'(1);
                end else if (r_cmd == CMD_REMOVE) begin
                    n_pos = ADDR_W'(r_idx);
                    if (w_idx_more) begin
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            S_SHIFT_RD: begin
                o_mem_ctl.rd_en = 1'b1;
                n_state         = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_mem_wdata     = i_mem_rdata;
                if (w_shift_more) begin
                    n_pos   = r_pos + ADDR_W'(1);
                    n_state = S_SHIFT_RD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = DATA_OUT_W'(r_dout);
                    n_out_status = r_res_status;
                    n_out_count  = COUNT_OUT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_word       <= n_word;
        r_pos        <= n_pos;
        r_dout       <= n_dout;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_status;
    assign o_count_out = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_front} < (ADDR_W + 1)'(CAPACITY))
        else $error("front pointer outside the ring");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.wr_en |-> (r_state == S_DECODE || r_state == S_SHIFT_WR))
        else $error("store written outside a write phase");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("new item taken while one is at work");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the finish phase");

endmodule

`default_nettype wire
